// File: hw/rtl/inv3_pkg.sv
package inv3_pkg;

  localparam int VW    = 32;            // value width, Q16.16 by default
  localparam int NCOF  = 9;
  localparam int PW    = 2 * VW;        // one element product
  localparam int COFW  = 2 * VW + 1;    // cofactor
  localparam int CMAGW = 2 * VW;        // cofactor magnitude
  localparam int LPW   = 2 * VW + 1;    // partial product of the determinant
  localparam int DETW  = 3 * VW + 1;    // determinant
  localparam int MAGW  = 3 * VW;        // determinant magnitude

  typedef logic signed [VW-1:0]   val_t;
  typedef logic signed [COFW-1:0] cof_t;
  typedef logic signed [DETW-1:0] det_t;

  typedef struct packed {
    val_t col0_x, col0_y, col0_z;
    val_t col1_x, col1_y, col1_z;
    val_t col2_x, col2_y, col2_z;
  } cols_t;

  typedef struct packed {
    val_t inv_r0_c0, inv_r0_c1, inv_r0_c2;
    val_t inv_r1_c0, inv_r1_c1, inv_r1_c2;
    val_t inv_r2_c0, inv_r2_c1, inv_r2_c2;
    logic singular;
    logic saturated;
  } inv_t;

  // cofactors and determinant handed to the divider array
  typedef struct packed {
    logic                  valid;
    cof_t [NCOF-1:0]       cof;
    det_t                  det;
  } adj_t;

endpackage

// File: hw/rtl/inv3_adj.sv
module inv3_adj import inv3_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  ce,
  input  logic  in_valid,
  input  cols_t in,
  output adj_t  out
);

  val_t a, b, c, d, e, f, g, h, k;

  assign a = in.col0_x;
  assign d = in.col0_y;
  assign g = in.col0_z;
  assign b = in.col1_x;
  assign e = in.col1_y;
  assign h = in.col1_z;
  assign c = in.col2_x;
  assign f = in.col2_y;
  assign k = in.col2_z;

  logic signed [PW-1:0]  pp [NCOF];
  logic signed [PW-1:0]  pq [NCOF];
  logic signed [LPW-1:0] lo_prod [3];
  logic signed [LPW-1:0] hi_prod [3];
  det_t                  term [3];
  cof_t                  s2_cof [NCOF];
  cof_t                  s3_cof [NCOF];
  cof_t                  s4_cof [NCOF];
  val_t                  s1_a, s1_b, s1_c, s2_a, s2_b, s2_c;
  logic                  s1_valid, s2_valid, s3_valid, s4_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
    end else if (ce) begin
      s1_valid  <= in_valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      s4_valid  <= s3_valid;
    end
  end

  // stage 1: the eighteen element products
  always_ff @(posedge clk) begin
    if (ce) begin
      pp[0] <= e * k;  pq[0] <= f * h;
      pp[1] <= c * h;  pq[1] <= b * k;
      pp[2] <= b * f;  pq[2] <= c * e;
      pp[3] <= f * g;  pq[3] <= d * k;
      pp[4] <= a * k;  pq[4] <= c * g;
      pp[5] <= c * d;  pq[5] <= a * f;
      pp[6] <= d * h;  pq[6] <= e * g;
      pp[7] <= b * g;  pq[7] <= a * h;
      pp[8] <= a * e;  pq[8] <= b * d;
      s1_a  <= a;
      s1_b  <= b;
      s1_c  <= c;
    end
  end

  // stage 2: cofactors
  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < NCOF; i++) begin
        s2_cof[i] <= COFW'(pp[i]) - COFW'(pq[i]);
      end
      s2_a <= s1_a;
      s2_b <= s1_b;
      s2_c <= s1_c;
    end
  end

  // stage 3: first row times cofactors, cofactor split in two halves
  always_ff @(posedge clk) begin
    if (ce) begin
      lo_prod[0] <= s2_a * $signed({1'b0, s2_cof[0][VW-1:0]});
      hi_prod[0] <= s2_a * $signed(s2_cof[0][COFW-1:VW]);
      lo_prod[1] <= s2_b * $signed({1'b0, s2_cof[3][VW-1:0]});
      hi_prod[1] <= s2_b * $signed(s2_cof[3][COFW-1:VW]);
      lo_prod[2] <= s2_c * $signed({1'b0, s2_cof[6][VW-1:0]});
      hi_prod[2] <= s2_c * $signed(s2_cof[6][COFW-1:VW]);
      s3_cof     <= s2_cof;
    end
  end

  // stage 4: recombine halves
  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        term[i] <= $signed({hi_prod[i], {VW{1'b0}}}) + DETW'(lo_prod[i]);
      end
      s4_cof <= s3_cof;
    end
  end

  // stage 5: determinant
  always_ff @(posedge clk) begin
    if (rst) begin
      out.valid <= 1'b0;
    end else if (ce) begin
      out.valid <= s4_valid;
      out.det <= term[0] + term[1] + term[2];
      for (int i = 0; i < NCOF; i++) begin
        out.cof[i] <= s4_cof[i];
      end
    end
  end

endmodule

// File: hw/rtl/inv3_div.sv
module inv3_div import inv3_pkg::*; #(
  parameter int FRACTION_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic ce,
  input  adj_t in,
  output logic out_valid,
  output inv_t out
);

  localparam int NW = CMAGW + 2 * FRACTION_BITS;   // scaled numerator
  localparam int HW = NW - VW;                     // numerator above the quotient bits
  localparam int CW = (HW > MAGW) ? HW : MAGW;
  localparam logic [VW-1:0] LIM_POS = {1'b0, {(VW-1){1'b1}}};
  localparam logic [VW-1:0] LIM_NEG = {1'b1, {(VW-1){1'b0}}};

  // sign and magnitude stage
  logic [CMAGW-1:0] cmag [NCOF];
  logic             sneg [NCOF];
  logic [MAGW-1:0]  dmag;
  logic             a_valid;

  // long division steps, index 0 is the setup stage
  logic [MAGW-1:0]  rem  [VW+1][NCOF];
  logic [VW-1:0]    quo  [VW+1][NCOF];
  logic [VW-1:0]    nl   [VW+1][NCOF];
  logic             ngv  [VW+1][NCOF];
  logic             ovr  [VW+1][NCOF];
  logic [MAGW-1:0]  dstg [VW+1];
  logic             sing [VW+1];
  logic             vld  [VW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      vld[0]  <= 1'b0;
    end else if (ce) begin
      a_valid <= in.valid;
      vld[0]  <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int l = 0; l < NCOF; l++) begin
        cmag[l] <= in.cof[l][COFW-1] ? CMAGW'(-$signed(in.cof[l])) : CMAGW'(in.cof[l]);
        sneg[l] <= in.cof[l][COFW-1] ^ in.det[DETW-1];
      end
      dmag <= in.det[DETW-1] ? MAGW'(-$signed(in.det)) : MAGW'(in.det);
    end
  end

  // setup: quotient bits above the value width mean the entry saturates
  logic [NW-1:0] nwide [NCOF];
  logic [HW-1:0] nhigh [NCOF];
  logic          over0 [NCOF];

  always_comb begin
    for (int l = 0; l < NCOF; l++) begin
      nwide[l] = {cmag[l], {(2 * FRACTION_BITS){1'b0}}};
      nhigh[l] = nwide[l][NW-1:VW];
      over0[l] = CW'(nhigh[l]) >= CW'(dmag);
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int l = 0; l < NCOF; l++) begin
        rem[0][l] <= over0[l] ? '0 : MAGW'(nhigh[l]);
        quo[0][l] <= '0;
        nl[0][l]  <= nwide[l][VW-1:0];
        ngv[0][l] <= sneg[l];
        ovr[0][l] <= over0[l];
      end
      dstg[0] <= dmag;
      sing[0] <= (dmag == '0);
    end
  end

  for (genvar j = 0; j < VW; j++) begin : g_step
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else if (ce) begin
        vld[j+1] <= vld[j];
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        dstg[j+1] <= dstg[j];
        sing[j+1] <= sing[j];
      end
    end

    for (genvar l = 0; l < NCOF; l++) begin : g_lane
      logic [MAGW:0] trial;
      logic          ge;

      assign trial = {rem[j][l], nl[j][l][VW-1]};
      assign ge    = trial >= {1'b0, dstg[j]};

      always_ff @(posedge clk) begin
        if (ce) begin
          rem[j+1][l] <= ge ? MAGW'(trial - {1'b0, dstg[j]}) : MAGW'(trial);
          quo[j+1][l] <= {quo[j][l][VW-2:0], ge};
          nl[j+1][l]  <= {nl[j][l][VW-2:0], 1'b0};
          ngv[j+1][l] <= ngv[j][l];
          ovr[j+1][l] <= ovr[j][l];
        end
      end
    end
  end

  // saturate, apply sign, force zero when singular
  logic [VW-1:0] lim   [NCOF];
  logic [VW-1:0] mag   [NCOF];
  logic [VW-1:0] value [NCOF];
  logic          clip  [NCOF];
  logic          clip_any;
  logic          zero;
  inv_t          out_next;

  always_comb begin
    clip_any = 1'b0;
    zero     = sing[VW];
    for (int l = 0; l < NCOF; l++) begin
      lim[l]   = ngv[VW][l] ? LIM_NEG : LIM_POS;
      clip[l]  = ovr[VW][l] || (quo[VW][l] > lim[l]);
      mag[l]   = clip[l] ? lim[l] : quo[VW][l];
      value[l] = ngv[VW][l] ? VW'(-mag[l]) : mag[l];
      if (zero) begin
        value[l] = '0;
      end
      clip_any = clip_any | clip[l];
    end
    out_next.inv_r0_c0 = value[0];
    out_next.inv_r0_c1 = value[1];
    out_next.inv_r0_c2 = value[2];
    out_next.inv_r1_c0 = value[3];
    out_next.inv_r1_c1 = value[4];
    out_next.inv_r1_c2 = value[5];
    out_next.inv_r2_c0 = value[6];
    out_next.inv_r2_c1 = value[7];
    out_next.inv_r2_c2 = value[8];
    out_next.singular  = zero;
    out_next.saturated = clip_any && !zero;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ce) begin
      out_valid <= vld[VW];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      out <= out_next;
    end
  end

endmodule

// File: hw/rtl/inverse_3x3_from_columns.sv
// 3x3 matrix inverse by the adjugate, signed fixed point (Q16.16 by default).
// cols channel: one transaction carries the three column vectors of a matrix;
// inv channel: one transaction carries the row-major inverse, a singular flag
// (determinant exactly zero, all entries zero) and a saturated flag (an entry
// was clipped to the value range). Entries are truncated toward zero.
// Both channels use valid/stall; a transaction completes when valid is high
// and stall is low. One matrix enters and one result leaves per cycle while
// inv_stall does not hold the output. From accepted input to result valid:
// five stages for products, cofactors and determinant, two for magnitudes and
// divider setup, one quotient bit per stage over the 32-bit value width, one
// output stage. The nine cofactor divisions run in parallel lanes sharing one
// determinant. When inv_stall holds the output, the whole pipeline freezes;
// one more input transaction is still taken into a skid register, after which
// cols_stall rises until the pipeline moves again. Reset clears all valid bits
// and the skid register; no result is pending afterwards.
module inverse_3x3_from_columns import inv3_pkg::*; #(
  parameter int FRACTION_BITS = 16
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  cols_valid,
  output logic  cols_stall,
  input  cols_t cols,
  output logic  inv_valid,
  input  logic  inv_stall,
  output inv_t  inv
);

  logic  ce;
  logic  skid_valid;
  cols_t skid_data;
  logic  pipe_valid;
  cols_t pipe_data;
  adj_t  adj;

  assign ce         = !inv_valid || !inv_stall;
  assign cols_stall = skid_valid;
  assign pipe_valid = skid_valid || cols_valid;
  assign pipe_data  = skid_valid ? skid_data : cols;

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (ce) begin
        skid_valid <= 1'b0;
      end
    end else if (cols_valid && !ce) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_valid && cols_valid && !ce) begin
      skid_data <= cols;
    end
  end

  inv3_adj u_adj (
    .clk      (clk),
    .rst      (rst),
    .ce       (ce),
    .in_valid (pipe_valid),
    .in       (pipe_data),
    .out      (adj)
  );

  inv3_div #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in        (adj),
    .out_valid (inv_valid),
    .out       (inv)
  );

`ifndef SYNTH
  // a singular result never reports clipping and carries zero diagonal entries
  assert property (@(posedge clk) disable iff (rst)
    (inv_valid && inv.singular) |-> (!inv.saturated && inv.inv_r0_c0 == '0
      && inv.inv_r1_c1 == '0 && inv.inv_r2_c2 == '0))
    else $error("singular result with nonzero entries or saturated flag");

  // a held transaction in the skid drains as soon as the pipeline moves
  assert property (@(posedge clk) disable iff (rst)
    (skid_valid && ce) |=> !skid_valid)
    else $error("skid register did not drain");

  // while frozen, the skid keeps its transaction
  assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !ce) |=> (skid_valid && $stable(skid_data)))
    else $error("skid transaction lost while frozen");

  // the skid only fills when the pipeline is frozen
  assert property (@(posedge clk) disable iff (rst)
    (!skid_valid && ce) |=> !skid_valid)
    else $error("skid filled while pipeline advancing");
`endif

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import inv3_pkg::*;

  localparam int FB        = 16;
  localparam int N_RANDOM  = 1300;
  localparam int CYCLE_CAP = 400000;

  logic  clk;
  logic  rst;
  logic  cols_valid;
  logic  cols_stall;
  cols_t cols;
  logic  inv_valid;
  logic  inv_stall;
  inv_t  inv;

  inverse_3x3_from_columns #(.FRACTION_BITS(FB)) DUT (
    .clk(clk), .rst(rst),
    .cols_valid(cols_valid), .cols_stall(cols_stall), .cols(cols),
    .inv_valid(inv_valid), .inv_stall(inv_stall), .inv(inv)
  );

  // exact adjugate inverse with truncation toward zero and clipping
  function automatic inv_t invert_exact(cols_t m);
    logic signed [255:0] a, b, c, d, e, f, g, h, k, det;
    logic signed [255:0] cf [9];
    logic [255:0] num, den, quo, lim;
    logic neg;
    inv_t r;
    logic [VW-1:0] ent [9];
    a = m.col0_x; d = m.col0_y; g = m.col0_z;
    b = m.col1_x; e = m.col1_y; h = m.col1_z;
    c = m.col2_x; f = m.col2_y; k = m.col2_z;
    cf[0] = e * k - f * h;
    cf[1] = c * h - b * k;
    cf[2] = b * f - c * e;
    cf[3] = f * g - d * k;
    cf[4] = a * k - c * g;
    cf[5] = c * d - a * f;
    cf[6] = d * h - e * g;
    cf[7] = b * g - a * h;
    cf[8] = a * e - b * d;
    det = a * cf[0] + b * cf[3] + c * cf[6];
    r = '0;
    if (det == 0) begin
      r.singular = 1'b1;
      return r;
    end
    den = (det < 0) ? -det : det;
    for (int i = 0; i < 9; i++) begin
      neg = (cf[i] < 0) != (det < 0);
      num = (cf[i] < 0) ? -cf[i] : cf[i];
      num = num << (2 * FB);
      quo = num / den;
      lim = 256'd1 << (VW - 1);
      if (!neg) lim = lim - 1;
      if (quo > lim) begin
        quo = lim;
        r.saturated = 1'b1;
      end
      if (neg) quo = -quo;
      ent[i] = quo[VW-1:0];
    end
    {r.inv_r0_c0, r.inv_r0_c1, r.inv_r0_c2, r.inv_r1_c0, r.inv_r1_c1, r.inv_r1_c2,
     r.inv_r2_c0, r.inv_r2_c1, r.inv_r2_c2} = {ent[0], ent[1], ent[2], ent[3], ent[4],
                                              ent[5], ent[6], ent[7], ent[8]};
    return r;
  endfunction

  class inverse_scoreboard;
    inv_t pending[$];
    int   mismatches;
    int   matrices;
    int   singulars;
    int   clipped;

    function void note_matrix(cols_t m);
      inv_t x;
      x = invert_exact(m);
      pending = {pending, x};
      matrices++;
      if (x.singular) singulars++;
      if (x.saturated) clipped++;
    endfunction

    function void check_inverse(inv_t got);
      inv_t want;
      string names [9] = '{"inv_r0_c0", "inv_r0_c1", "inv_r0_c2", "inv_r1_c0",
                           "inv_r1_c1", "inv_r1_c2", "inv_r2_c0", "inv_r2_c1", "inv_r2_c2"};
      logic [VW-1:0] w, g;
      if (pending.size() == 0) begin
        $error("inverse transaction with nothing expected");
        mismatches++;
        return;
      end
      want = pending.pop_front();
      for (int i = 0; i < 9; i++) begin
        w = want[2 + VW * (8 - i) +: VW];
        g = got[2 + VW * (8 - i) +: VW];
        if (w !== g) begin
          $error("%s expected %h actual %h", names[i], w, g);
          mismatches++;
        end
      end
      if (want.singular !== got.singular) begin
        $error("singular expected %b actual %b", want.singular, got.singular);
        mismatches++;
      end
      if (want.saturated !== got.saturated) begin
        $error("saturated expected %b actual %b", want.saturated, got.saturated);
        mismatches++;
      end
    endfunction
  endclass

  inverse_scoreboard sb;
  int cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    sb = new();
    rst = 1'b1;
    cols_valid = 1'b0;
    cols = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst) begin
      if (cols_valid && !cols_stall) sb.note_matrix(cols);
      if (inv_valid && !inv_stall) sb.check_inverse(inv);
    end
  end

  initial cycles = 0;

  // receiver backpressure in phases: none, light, heavy
  int stall_mode;
  int stall_left;
  initial begin
    inv_stall = 1'b0;
    stall_mode = 0;
    stall_left = 0;
  end
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(10, 120);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: inv_stall <= 1'b0;
      1: inv_stall <= ($urandom_range(0, 99) < 25);
      default: inv_stall <= ($urandom_range(0, 99) < 75);
    endcase
  end

  function automatic cols_t mk(val_t c0x, val_t c0y, val_t c0z, val_t c1x, val_t c1y,
                               val_t c1z, val_t c2x, val_t c2y, val_t c2z);
    cols_t m;
    m = {c0x, c0y, c0z, c1x, c1y, c1z, c2x, c2y, c2z};
    return m;
  endfunction

  function automatic val_t pick_value();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1, 2: return val_t'($urandom);
      3: return val_t'($urandom_range(0, 3)) << 30 | val_t'($urandom_range(0, 7));
      4: return val_t'(32'h8000_0000 + $urandom_range(0, 2));
      5: return val_t'(32'h7fff_ffff - $urandom_range(0, 2));
      6: return val_t'($urandom_range(0, 16)) - val_t'(8);
      default: return val_t'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
    endcase
  endfunction

  function automatic cols_t random_matrix();
    cols_t m;
    int sel;
    m = mk(pick_value(), pick_value(), pick_value(), pick_value(), pick_value(),
           pick_value(), pick_value(), pick_value(), pick_value());
    sel = $urandom_range(0, 9);
    // rank-deficient cases: repeated column or zero column
    if (sel == 0) {m.col2_x, m.col2_y, m.col2_z} = {m.col0_x, m.col0_y, m.col0_z};
    else if (sel == 1) {m.col1_x, m.col1_y, m.col1_z} = '0;
    return m;
  endfunction

  int burst_left;
  task automatic send_matrix(cols_t m);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        cols_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    cols_valid <= 1'b1;
    cols <= m;
    @(posedge clk);
    while (cols_stall) @(posedge clk);
  endtask

  localparam val_t ONE = val_t'(1 << FB);
  localparam val_t VMAX = 32'sh7fff_ffff;
  localparam val_t VMIN = 32'sh8000_0000;

  initial begin
    burst_left = 0;
    @(negedge rst);
    @(posedge clk);
    send_matrix(mk(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE));
    send_matrix(mk(-ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE));
    send_matrix('0);
    send_matrix(mk(1, 0, 0, 0, 1, 0, 0, 0, 1));
    send_matrix(mk(-1, 0, 0, 0, 1, 0, 0, 0, -1));
    send_matrix({9{VMAX}});
    send_matrix({9{VMIN}});
    send_matrix(mk(VMAX, 0, 0, 0, VMAX, 0, 0, 0, VMAX));
    send_matrix(mk(VMIN, 0, 0, 0, VMIN, 0, 0, 0, VMIN));
    send_matrix(mk(VMIN, VMAX, 0, VMAX, VMIN, 0, 0, 0, VMAX));
    send_matrix(mk(2 * ONE, 0, 0, 0, 4 * ONE, 0, 0, 0, -8 * ONE));
    send_matrix(mk(ONE, 2 * ONE, 3 * ONE, 4 * ONE, 5 * ONE, 6 * ONE,
                   7 * ONE, 8 * ONE, 10 * ONE));
    send_matrix(mk(ONE, 2 * ONE, 3 * ONE, 4 * ONE, 5 * ONE, 6 * ONE,
                   7 * ONE, 8 * ONE, 9 * ONE));
    send_matrix(mk(0, ONE, 0, ONE, 0, 0, 0, 0, ONE));
    send_matrix(mk(ONE, ONE, 0, 0, ONE, ONE, ONE, 0, ONE));
    send_matrix(mk(VMAX, VMIN, 1, -1, VMAX, 0, 3, 0, VMIN));
    send_matrix(mk(-1, -1, -1, -1, -1, -1, -1, -1, -1));
    for (int i = 0; i < N_RANDOM; i++) send_matrix(random_matrix());
    cols_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("covered %0d matrices: %0d singular, %0d with clipped entries",
             sb.matrices, sb.singulars, sb.clipped);
    $display("receiver stalled in phases, sender ran in bursts with random gaps");
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_CAP) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

endmodule
